// ===== rtl/ctl_pkg.sv =====
// ----------------------------------------------------------------------------
// ctl_pkg
// shared types and constants of the calculator token lexer
// ----------------------------------------------------------------------------
package ctl_pkg;

	localparam int MaxWordChars = 8;
	localparam int LenW = $clog2(MaxWordChars + 2);
	localparam logic [62:0] NumLimit = {63{1'b1}};

	localparam logic [1:0] RES_TOKEN = 2'd0;
	localparam logic [1:0] RES_BADWORD = 2'd1;
	localparam logic [1:0] RES_OPENCOMMENT = 2'd2;

	localparam logic [4:0] KIND_NUMBER = 5'd26;

	localparam logic [1:0] MODE_UNDECIDED = 2'd0;
	localparam logic [1:0] MODE_DEC = 2'd1;
	localparam logic [1:0] MODE_HEX = 2'd2;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [4:0]  token_kind;
		logic [62:0] token_value;
		logic        last_of_run;
	} result_t;

	// one classified character event passed to the back part
	typedef struct packed {
		logic       flush;
		logic       emit_op;
		logic [3:0] op;
		logic       open_err;
		logic       append;
		logic       eot;
		logic [7:0] ch;
	} event_t;

	function automatic logic [4:0] op_code(input logic [7:0] c);
		case (c)
			8'h2E: op_code = 5'd0;
			8'h2C: op_code = 5'd1;
			8'h2B: op_code = 5'd2;
			8'h2D: op_code = 5'd3;
			8'h2A: op_code = 5'd4;
			8'h2F: op_code = 5'd5;
			8'h25: op_code = 5'd6;
			8'h40: op_code = 5'd7;
			8'h7C: op_code = 5'd8;
			8'h3C: op_code = 5'd9;
			8'h3E: op_code = 5'd10;
			8'h26: op_code = 5'd11;
			8'h7E: op_code = 5'd12;
			8'h21: op_code = 5'd13;
			8'h3F: op_code = 5'd14;
			8'h3A: op_code = 5'd15;
			default: op_code = 5'd16;
		endcase
	endfunction

	function automatic logic [4:0] digit_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) digit_value = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) digit_value = 5'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) digit_value = 5'(c - 8'h37);
		else digit_value = 5'd31;
	endfunction

endpackage

// ===== rtl/ctl_front.sv =====
// ----------------------------------------------------------------------------
// ctl_front
// classifies characters and tracks comments, emits events into a queue
// ----------------------------------------------------------------------------
module ctl_front import ctl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_eot,
	output logic       ev_valid,
	input  logic       ev_ready,
	output event_t     ev
);

	logic   in_comment_q;
	event_t e;
	logic   useful;
	logic [4:0] opc;
	logic   space;

	// two-entry queue
	event_t q_mem_q [2];
	logic   wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign opc = op_code(in_char);
	assign space = (in_char == 8'h20) || (in_char >= 8'h09 && in_char <= 8'h0D);

	always_comb begin
		e = '0;
		e.ch = in_char;
		if (in_eot) begin
			e.eot = 1'b1;
			e.open_err = in_comment_q;
			e.flush = !in_comment_q;
		end else if (!in_comment_q) begin
			if (!opc[4]) begin
				e.flush = 1'b1;
				e.emit_op = 1'b1;
				e.op = opc[3:0];
			end else if (space || in_char == 8'h5C) begin
				e.flush = 1'b1;
			end else begin
				e.append = 1'b1;
			end
		end
		useful = e.flush || e.append || e.open_err || e.eot;
	end

	assign push = in_valid && in_ready && useful;
	assign ev_valid = (cnt_q != 2'd0);
	assign ev = q_mem_q[rd_q];
	assign pop = ev_valid && ev_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_comment_q <= 1'b0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				if (in_eot) in_comment_q <= 1'b0;
				else if (in_comment_q) begin
					if (in_char == 8'h5C) in_comment_q <= 1'b0;
				end else if (opc[4] && in_char == 8'h5C) in_comment_q <= 1'b1;
			end
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_q] <= e;
	end

endmodule

// ===== rtl/ctl_back.sv =====
// ----------------------------------------------------------------------------
// ctl_back
// builds words and numbers, matches keywords, emits result words
// ----------------------------------------------------------------------------
module ctl_back import ctl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    ev_valid,
	output logic    ev_ready,
	input  event_t  ev,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	logic [7:0] chars_q [MaxWordChars];
	logic [LenW-1:0] len_q;
	logic [62:0] acc_q;
	logic nvalid_q, sat_q;
	logic [1:0] mode_q;

	// output: up to two pending results
	result_t r0_q, r1_q;
	logic [1:0] oc_q;

	logic [4:0] kw;
	logic flush_has;
	result_t wres, ores, eres;
	logic [1:0] n;

	function automatic logic eqw(input logic [7:0] a [MaxWordChars],
			input logic [LenW-1:0] l, input logic [63:0] s, input int sl);
		logic ok;
		ok = (int'(l) == sl);
		for (int i = 0; i < 8; i++)
			if (i < sl && i < MaxWordChars) ok = ok && (a[i] == s[8*(sl-1-i) +: 8]);
		if (sl > MaxWordChars) ok = 1'b0;
		return ok;
	endfunction

	always_comb begin
		kw = 5'd31;
		if (eqw(chars_q, len_q, 64'("dup"), 3)) kw = 5'd0;
		if (eqw(chars_q, len_q, 64'("pop"), 3)) kw = 5'd1;
		if (eqw(chars_q, len_q, 64'("hex"), 3)) kw = 5'd16;
		if (eqw(chars_q, len_q, 64'("print"), 5)) kw = 5'd17;
		if (eqw(chars_q, len_q, 64'("sectors"), 7)) kw = 5'd18;
		if (eqw(chars_q, len_q, 64'("heads"), 5)) kw = 5'd19;
		if (eqw(chars_q, len_q, 64'("exit"), 4)) kw = 5'd20;
		if (eqw(chars_q, len_q, 64'("add"), 3)) kw = 5'd2;
		if (eqw(chars_q, len_q, 64'("sub"), 3)) kw = 5'd3;
		if (eqw(chars_q, len_q, 64'("mul"), 3)) kw = 5'd4;
		if (eqw(chars_q, len_q, 64'("div"), 3)) kw = 5'd5;
		if (eqw(chars_q, len_q, 64'("mod"), 3)) kw = 5'd6;
		if (eqw(chars_q, len_q, 64'("chs"), 3)) kw = 5'd7;
		if (eqw(chars_q, len_q, 64'("or"), 2)) kw = 5'd8;
		if (eqw(chars_q, len_q, 64'("and"), 3)) kw = 5'd11;
		if (eqw(chars_q, len_q, 64'("not"), 3)) kw = 5'd12;
		if (eqw(chars_q, len_q, 64'("shl"), 3)) kw = 5'd9;
		if (eqw(chars_q, len_q, 64'("shr"), 3)) kw = 5'd10;
		if (eqw(chars_q, len_q, 64'("lnot"), 4)) kw = 5'd13;
		if (eqw(chars_q, len_q, 64'("cond"), 4)) kw = 5'd14;
		if (eqw(chars_q, len_q, 64'("seg"), 3)) kw = 5'd15;
		if (eqw(chars_q, len_q, 64'("label"), 5)) kw = 5'd21;
		if (eqw(chars_q, len_q, 64'("goto"), 4)) kw = 5'd22;
		if (eqw(chars_q, len_q, 64'("gotoif"), 6)) kw = 5'd23;
		if (eqw(chars_q, len_q, 64'("get"), 3)) kw = 5'd24;
		if (eqw(chars_q, len_q, 64'("set"), 3)) kw = 5'd25;

		flush_has = ev.flush && (len_q != '0);
		wres = '0;
		if (kw != 5'd31) wres.token_kind = kw;
		else if (nvalid_q) begin
			wres.token_kind = KIND_NUMBER;
			wres.token_value = acc_q;
		end else wres.result_kind = RES_BADWORD;
		wres.last_of_run = !ev.emit_op;

		ores = '0;
		ores.token_kind = {1'b0, ev.op};
		ores.last_of_run = 1'b1;
		eres = '0;
		eres.result_kind = RES_OPENCOMMENT;
		eres.last_of_run = 1'b1;

		n = 2'(flush_has) + 2'(ev.emit_op) + 2'(ev.open_err);
	end

	// number digit update
	logic [4:0] dv;
	logic [3:0] base;
	logic feed, is_pfx, go_dec, bad;
	logic [1:0] nmode;
	logic [66:0] prod;
	logic [66:0] nxt;

	always_comb begin
		dv = digit_value(ev.ch);
		nmode = mode_q;
		feed = 1'b0;
		is_pfx = 1'b0;
		go_dec = 1'b0;
		if (len_q == '0) begin
			if (ev.ch == 8'h24) begin
				nmode = MODE_HEX;
				is_pfx = 1'b1;
			end else if (ev.ch == 8'h30) is_pfx = 1'b1;
			else go_dec = 1'b1;
		end else if (mode_q == MODE_UNDECIDED) begin
			if (ev.ch == 8'h78) begin
				nmode = MODE_HEX;
				is_pfx = 1'b1;
			end else go_dec = 1'b1;
		end
		if (go_dec) nmode = MODE_DEC;
		feed = !is_pfx;
		base = (nmode == MODE_HEX) ? 4'd15 : 4'd9;
		bad = feed && (dv > 5'(base));
		prod = (nmode == MODE_HEX) ? {acc_q, 4'b0} : (67'(acc_q) << 3) + (67'(acc_q) << 1);
		nxt = prod + 67'(dv[3:0]);
	end

	logic accept;
	assign ev_ready = (oc_q == 2'd0) || (out_ready && oc_q == 2'd1);
	assign accept = ev_valid && ev_ready;
	assign out_valid = (oc_q != 2'd0);
	assign out_res = r0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q <= 2'd0;
			len_q <= '0;
			acc_q <= '0;
			nvalid_q <= 1'b1;
			sat_q <= 1'b0;
			mode_q <= MODE_UNDECIDED;
		end else begin
			if (accept) begin
				oc_q <= n;
				if (ev.flush || ev.eot) begin
					len_q <= '0;
					acc_q <= '0;
					nvalid_q <= 1'b1;
					sat_q <= 1'b0;
					mode_q <= MODE_UNDECIDED;
				end else if (ev.append) begin
					if (int'(len_q) <= MaxWordChars) len_q <= len_q + 1'b1;
					if (nvalid_q) begin
						mode_q <= nmode;
						if (bad) nvalid_q <= 1'b0;
						else if (feed && !sat_q) begin
							if (nxt > 67'(NumLimit)) begin
								acc_q <= NumLimit;
								sat_q <= 1'b1;
							end else acc_q <= nxt[62:0];
						end
					end
				end
			end else if (out_valid && out_ready) begin
				oc_q <= oc_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (ev.append && int'(len_q) < MaxWordChars)
				chars_q[len_q[$clog2(MaxWordChars)-1:0]] <= ev.ch;
			if (flush_has) begin
				r0_q <= wres;
				r1_q <= ores;
			end else if (ev.emit_op) begin
				r0_q <= ores;
			end else begin
				r0_q <= eres;
			end
		end else if (out_valid && out_ready) begin
			r0_q <= r1_q;
		end
	end

endmodule

// ===== rtl/calc_token_lexer.sv =====
// ----------------------------------------------------------------------------
// calc_token_lexer
// character-serial lexer for a small stack calculator
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser  tlast
// s_axis   in   char_code[7:0]                 eot    -
// m_axis   out  kind[1:0] token[6:2] val[69:7] -      last_of_run
//
// one character a cycle in while the queue has room; a word end gives up to two
// result words, taken one a cycle while the output is ready, so input stalls once the queue fills.
// the front tracks comments and feeds a two-entry queue; the back holds the
// word buffer, number accumulator and keyword compare.
// reset clears all control state; a word's chars need no reset.
// ----------------------------------------------------------------------------
module calc_token_lexer import ctl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // char_code
	input  logic        s_axis_tuser,  // end_of_text
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // result_kind, token_kind, token_value, zeros
	output logic        m_axis_tlast
);

	logic   ev_valid, ev_ready;
	event_t ev;
	result_t res;

	ctl_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_char(s_axis_tdata), .in_eot(s_axis_tuser),
		.ev_valid, .ev_ready, .ev
	);

	ctl_back u_back (
		.clk, .arst_n,
		.ev_valid, .ev_ready, .ev,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tdata = {2'b00, res.token_value, res.token_kind, res.result_kind};
	assign m_axis_tlast = res.last_of_run;

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.result_kind != RES_TOKEN |-> res.token_kind == 5'd0)
		else $error("error result with nonzero token kind");
	a_val: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.token_kind != KIND_NUMBER |-> res.token_value == 63'd0)
		else $error("value on non-number");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped");

endmodule
